[rtl/mtsr_pkg.sv]
// mtsr_pkg: shared types, widths and constants of the multitouch slot tracker
// no dependencies; imported by every module of the block
package mtsr_pkg;

    // slot table
    localparam int SLOTS   = 10;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;

    // input fields
    localparam int CMD_W   = 3;
    localparam int VAL_W   = 32;
    localparam int SEC_W   = 16;
    localparam int USEC_W  = 20;
    localparam int IN_TDATA_W = 72;

    // result fields
    localparam int COORD_W = 16;
    localparam int SCAN_W  = 16;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (SLOT_W + 2 * COORD_W + CNT_W + SCAN_W);

    // usec / 100 as multiply by reciprocal, exact for all 20-bit inputs
    localparam int USEC_RECIP_W = 21;
    localparam logic [USEC_RECIP_W-1:0] USEC_RECIP = 21'd1342178;
    localparam int USEC_SHIFT = 27;
    localparam int USEC_QUO_W = 14;
    localparam logic [SEC_W-1:0] TICKS_PER_SEC = 16'd10000;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SELECT = 3'd0,
        CMD_TRACK  = 3'd1,
        CMD_POS_X  = 3'd2,
        CMD_POS_Y  = 3'd3,
        CMD_SYNC   = 3'd4
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_back_state;

    // one classified operation as it travels through the queue
    typedef struct packed {
        t_cmd               op;
        logic               flag;   // select: slot in range, track: contact active
        logic [COORD_W-1:0] data;   // low bits of the event value
        logic [SCAN_W-1:0]  scan;
    } t_op_entry;

    typedef struct packed {
        logic               tip;
        logic [SLOT_W-1:0]  id;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CNT_W-1:0]   count;
        logic [SCAN_W-1:0]  scan;
        logic               last;
    } t_report;

endpackage

[rtl/mtsr_front.sv]
// mtsr_front: accepts input words, classifies commands, computes scan time
// depends on mtsr_pkg
module mtsr_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mtsr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic [mtsr_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                            o_push_valid,
    input  logic                            i_push_ready,
    output mtsr_pkg::t_op_entry             o_push_entry
);
    import mtsr_pkg::*;

    logic [VAL_W-1:0]  value;
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
    logic              accept;
    logic              keep;
    logic              flag;
    logic [USEC_W+USEC_RECIP_W-1:0] usec_prod;
    logic [SEC_W-1:0]  sec_ticks;

    logic                  r_stg_valid;
    t_cmd                  r_stg_op;
    logic                  r_stg_flag;
    logic [COORD_W-1:0]    r_stg_data;
    logic [USEC_QUO_W-1:0] r_stg_quo;
    logic [SEC_W-1:0]      r_stg_sec;

    assign value  = s_axis_tdata[VAL_W-1:0];
    assign sec    = s_axis_tdata[VAL_W +: SEC_W];
    assign usec   = s_axis_tdata[VAL_W+SEC_W +: USEC_W];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_stg_valid || i_push_ready;

    // command decode; codes above sync are dropped here
    always_comb begin
        keep = 1'b1;
        flag = 1'b0;
        unique case (s_axis_tuser) inside
            CMD_SELECT: flag = !value[VAL_W-1] && (value < VAL_W'(SLOTS));
            CMD_TRACK:  flag = (value != '1);
            CMD_POS_X, CMD_POS_Y, CMD_SYNC: flag = 1'b0;
            default:    keep = 1'b0;
        endcase
    end

    assign usec_prod = usec * USEC_RECIP;
    assign sec_ticks = sec * TICKS_PER_SEC;  // wraps mod 2^16

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (accept) begin
            r_stg_valid <= keep;
        end else if (i_push_ready) begin
            r_stg_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stg_op   <= t_cmd'(s_axis_tuser);
            r_stg_flag <= flag;
            r_stg_data <= value[COORD_W-1:0];
            r_stg_quo  <= usec_prod[USEC_SHIFT +: USEC_QUO_W];
            r_stg_sec  <= sec_ticks;
        end
    end

    assign o_push_valid      = r_stg_valid;
    assign o_push_entry.op   = r_stg_op;
    assign o_push_entry.flag = r_stg_flag;
    assign o_push_entry.data = r_stg_data;
    assign o_push_entry.scan = r_stg_sec + SCAN_W'(r_stg_quo);

endmodule

[rtl/mtsr_queue.sv]
// mtsr_queue: short fifo of classified operations between front and back
// depends on mtsr_pkg
module mtsr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  mtsr_pkg::t_op_entry i_push_entry,
    output logic                o_pop_valid,
    input  logic                i_pop_ready,
    output mtsr_pkg::t_op_entry o_pop_entry
);
    import mtsr_pkg::*;

    t_op_entry         r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;
    assign o_pop_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

[rtl/mtsr_back.sv]
// mtsr_back: slot table, sync scan sequencer and report output register
// depends on mtsr_pkg
module mtsr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pop_valid,
    output logic                o_pop_ready,
    input  mtsr_pkg::t_op_entry i_pop_entry,
    output logic                o_rep_valid,
    input  logic                i_rep_ready,
    output mtsr_pkg::t_report   o_report
);
    import mtsr_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    logic [SLOTS-1:0]   r_active;
    logic [SLOTS-1:0]   r_sent;
    logic [COORD_W-1:0] r_x [SLOTS];
    logic [COORD_W-1:0] r_y [SLOTS];
    logic [SLOT_W-1:0]  r_sel;
    logic               r_sel_ok;
    logic [SLOTS-1:0]   r_pend;
    logic [CNT_W-1:0]   r_count;
    logic [SCAN_W-1:0]  r_scan;
    t_report            r_out;
    logic               r_out_valid;

    logic               pop;
    logic               emit;
    logic               load_ok;
    logic [SLOTS-1:0]   pend_now;
    logic [SLOTS-1:0]   pend_rest;
    logic [SLOT_W-1:0]  first;
    logic [CNT_W-1:0]   cnt;

    assign pend_now = r_active | ~r_sent;
    assign load_ok  = !r_out_valid || i_rep_ready;

    // lowest pending slot
    always_comb begin
        first = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                first = SLOT_W'(i);
            end
        end
    end

    assign pend_rest = r_pend & ~(SLOTS'(1) << first);

    always_comb begin
        cnt = '0;
        for (int i = 0; i < SLOTS; i++) begin
            cnt = cnt + CNT_W'(pend_now[i]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_pop_valid && i_pop_entry.op == CMD_SYNC && pend_now != '0) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (load_ok && pend_rest == '0) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop_ready = 1'b0;
        emit        = 1'b0;
        unique case (r_state)
            BK_IDLE: o_pop_ready = 1'b1;
            BK_SCAN: emit = load_ok;
            default: o_pop_ready = 1'b0;
        endcase
    end

    assign pop = i_pop_valid && o_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_active    <= '0;
            r_sent      <= '0;
            r_sel       <= '0;
            r_sel_ok    <= 1'b1;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_x[i] <= '0;
                r_y[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (pop) begin
                case (i_pop_entry.op)
                    CMD_SELECT: begin
                        r_sel_ok <= i_pop_entry.flag;
                        if (i_pop_entry.flag) begin
                            r_sel <= i_pop_entry.data[SLOT_W-1:0];
                        end
                    end
                    CMD_TRACK: begin
                        if (r_sel_ok) begin
                            r_active[r_sel] <= i_pop_entry.flag;
                        end
                    end
                    CMD_POS_X: begin
                        if (r_sel_ok) begin
                            r_x[r_sel] <= i_pop_entry.data;
                        end
                    end
                    CMD_POS_Y: begin
                        if (r_sel_ok) begin
                            r_y[r_sel] <= i_pop_entry.data;
                        end
                    end
                    CMD_SYNC: r_sent <= ~r_active;
                    default: ;
                endcase
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rep_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan context and report payload
    always_ff @(posedge i_clk) begin
        if (pop && i_pop_entry.op == CMD_SYNC) begin
            r_pend  <= pend_now;
            r_count <= cnt;
            r_scan  <= i_pop_entry.scan;
        end else if (emit) begin
            r_pend <= pend_rest;
        end
        if (emit) begin
            r_out.tip   <= r_active[first];
            r_out.id    <= first;
            r_out.x     <= r_x[first];
            r_out.y     <= r_y[first];
            r_out.count <= r_count;
            r_out.scan  <= r_scan;
            r_out.last  <= (pend_rest == '0);
        end
    end

    assign o_rep_valid = r_out_valid;
    assign o_report    = r_out;

endmodule

[rtl/multitouch_slots_to_touch_reports_core.sv]
// multitouch_slots_to_touch_reports_core: slot-based touch events in, touch reports out
// depends on mtsr_pkg, mtsr_front, mtsr_queue, mtsr_back
//
// flow: an event word is registered in the front stage before it enters the queue; the
//   back end takes slot, position and tracking words while idle, and a sync scans out n
//   reports, n being the reports it sends (0 to 10), the first report loaded into the
//   output register from the scan state that the sync enters when it leaves the queue
// throughput: one report per cycle while the sink is ready; the front keeps taking
//   words into a four-entry queue while the back end scans a sync
// reset: synchronous active low; clears slot table, selection to slot 0, queue and
//   output register, with no clearing pass
module multitouch_slots_to_touch_reports_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: event_value[31:0], time_seconds[47:32], time_microseconds[67:48], zero pad
    input  logic [mtsr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: command[2:0]
    input  logic [mtsr_pkg::CMD_W-1:0]       s_axis_tuser,
    // report stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: contact_id[3:0], x_position[19:4], y_position[35:20],
    //        contact_count[40:36], scan_time[56:41], zero pad
    output logic [mtsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: tip_switch
    output logic                             m_axis_tuser,
    // tlast: last report of the sync
    output logic                             m_axis_tlast
);
    import mtsr_pkg::*;

    // front to queue
    logic      push_valid;
    logic      push_ready;
    t_op_entry push_entry;

    // queue to back end
    logic      pop_valid;
    logic      pop_ready;
    t_op_entry pop_entry;

    t_report   report;

    // decode and scan time arithmetic
    mtsr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_entry  (push_entry)
    );

    // decouples event intake from the sync scan
    mtsr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_entry  (pop_entry)
    );

    // slot table updates and report generation
    mtsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_entry (pop_entry),
        .o_rep_valid (m_axis_tvalid),
        .i_rep_ready (m_axis_tready),
        .o_report    (report)
    );

    // pack report fields, lowest field first
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, report.scan, report.count,
                           report.y, report.x, report.id};
    assign m_axis_tuser = report.tip;
    assign m_axis_tlast = report.last;

endmodule

[rtl/mtsr_checker.sv]
// mtsr_checker: port-level checks on the report stream, bound to the top level
// depends on mtsr_pkg and multitouch_slots_to_touch_reports_core
module mtsr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [mtsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser,
    input logic                             m_axis_tlast
);
    import mtsr_pkg::*;

    // stalled report holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("report changed while stalled");

    // contact id names a real slot
    a_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[SLOT_W-1:0] < SLOT_W'(SLOTS))
        else $error("contact id out of range");

    // contact count covers at least this report and at most all slots
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[40:36] != '0 && m_axis_tdata[40:36] <= CNT_W'(SLOTS))
        else $error("contact count out of range");

    // within a frame the next report follows at once, in slot order, same count and time
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[SLOT_W-1:0] > $past(m_axis_tdata[SLOT_W-1:0]))
            && $stable(m_axis_tdata[56:36]))
        else $error("frame reports broken");

endmodule

bind multitouch_slots_to_touch_reports_core mtsr_checker u_mtsr_checker (.*);

[tb/mtsr_report_checker.sv]
// mtsr_report_checker: watches both streams of the multitouch slot tracker, tracks slot state
// and compares every touch report word with the one predicted for it
// depends on mtsr_pkg
`timescale 1ns / 1ps

module mtsr_report_checker
    import mtsr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_evt_tvalid,
    input  logic                   i_evt_tready,
    input  logic [IN_TDATA_W-1:0]  i_evt_tdata,
    input  logic [CMD_W-1:0]       i_evt_tuser,
    input  logic                   i_rpt_tvalid,
    input  logic                   i_rpt_tready,
    input  logic [OUT_TDATA_W-1:0] i_rpt_tdata,
    input  logic                   i_rpt_tuser,
    input  logic                   i_rpt_tlast,
    output int                     o_fails,
    output int                     o_pending,
    output int                     o_words,
    output int                     o_reports
);

    localparam logic [VAL_W-1:0] RELEASE_ID = 32'hFFFF_FFFF;

    // report word layout
    localparam int X_LSB   = SLOT_W;
    localparam int Y_LSB   = X_LSB + COORD_W;
    localparam int CNT_LSB = Y_LSB + COORD_W;
    localparam int SCN_LSB = CNT_LSB + CNT_W;

    t_report            reports_due [$];
    logic               slot_live    [SLOTS];
    logic               release_done [SLOTS];
    logic [COORD_W-1:0] slot_x       [SLOTS];
    logic [COORD_W-1:0] slot_y       [SLOTS];
    logic [SLOT_W-1:0]  cur_slot;
    logic               cur_slot_ok;
    int                 fails;
    int                 words;
    int                 reports;

    function automatic logic [SCAN_W-1:0] scan_ticks(input logic [SEC_W-1:0]  sec,
                                                     input logic [USEC_W-1:0] usec);
        logic [31:0] ticks;
        ticks = 32'(usec) / 32'd100 + 32'(sec) * 32'd10000;
        return ticks[SCAN_W-1:0];
    endfunction

    task automatic clear_slots();
        for (int i = 0; i < SLOTS; i++) begin
            slot_live[i]    = 1'b0;
            release_done[i] = 1'b0;
            slot_x[i]       = '0;
            slot_y[i]       = '0;
        end
        cur_slot    = '0;
        cur_slot_ok = 1'b1;
        reports_due.delete();
    endtask

    // updates the slot table and queues the reports a sync produces
    task automatic track_event(input logic [CMD_W-1:0]  code,
                               input logic [VAL_W-1:0]  value,
                               input logic [SEC_W-1:0]  sec,
                               input logic [USEC_W-1:0] usec);
        t_report           rpt;
        logic [CNT_W-1:0]  in_frame;
        int                last_slot;
        case (code)
            CMD_SELECT: begin
                if (!value[VAL_W-1] && value < 32'(SLOTS)) begin
                    cur_slot    = value[SLOT_W-1:0];
                    cur_slot_ok = 1'b1;
                end else begin
                    cur_slot_ok = 1'b0;
                end
            end
            CMD_TRACK: if (cur_slot_ok) slot_live[cur_slot] = (value != RELEASE_ID);
            CMD_POS_X: if (cur_slot_ok) slot_x[cur_slot] = value[COORD_W-1:0];
            CMD_POS_Y: if (cur_slot_ok) slot_y[cur_slot] = value[COORD_W-1:0];
            CMD_SYNC: begin
                in_frame  = '0;
                last_slot = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_live[i] || !release_done[i]) begin
                        in_frame++;
                        last_slot = i;
                    end
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_live[i] || !release_done[i]) begin
                        rpt.tip   = slot_live[i];
                        rpt.id    = SLOT_W'(i);
                        rpt.x     = slot_x[i];
                        rpt.y     = slot_y[i];
                        rpt.count = in_frame;
                        rpt.scan  = scan_ticks(sec, usec);
                        rpt.last  = (i == last_slot);
                        reports_due.push_back(rpt);
                    end
                end
                for (int i = 0; i < SLOTS; i++)
                    release_done[i] = !slot_live[i];
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("report field %s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    initial begin
        fails   = 0;
        words   = 0;
        reports = 0;
        clear_slots();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_slots();
        end else begin
            if (i_rpt_tvalid && i_rpt_tready) begin
                reports++;
                if (reports_due.size() == 0) begin
                    $error("report word with none expected: id %0d",
                           i_rpt_tdata[SLOT_W-1:0]);
                    fails++;
                end else begin
                    automatic t_report want = reports_due.pop_front();
                    compare_field("tip_switch", 32'(want.tip), 32'(i_rpt_tuser));
                    compare_field("contact_id", 32'(want.id), 32'(i_rpt_tdata[SLOT_W-1:0]));
                    compare_field("x_position", 32'(want.x),
                                  32'(i_rpt_tdata[X_LSB +: COORD_W]));
                    compare_field("y_position", 32'(want.y),
                                  32'(i_rpt_tdata[Y_LSB +: COORD_W]));
                    compare_field("contact_count", 32'(want.count),
                                  32'(i_rpt_tdata[CNT_LSB +: CNT_W]));
                    compare_field("scan_time", 32'(want.scan),
                                  32'(i_rpt_tdata[SCN_LSB +: SCAN_W]));
                    compare_field("last_of_frame", 32'(want.last), 32'(i_rpt_tlast));
                end
            end
            if (i_evt_tvalid && i_evt_tready) begin
                words++;
                track_event(i_evt_tuser, i_evt_tdata[VAL_W-1:0],
                            i_evt_tdata[VAL_W +: SEC_W], i_evt_tdata[VAL_W+SEC_W +: USEC_W]);
            end
        end
        o_fails   <= fails;
        o_pending <= reports_due.size();
        o_words   <= words;
        o_reports <= reports;
    end

endmodule

[tb/tb.sv]
// tb: stimulus and verdict for multitouch_slots_to_touch_reports_core
// depends on mtsr_pkg, the core and mtsr_report_checker
`timescale 1ns / 1ps

module tb;
    import mtsr_pkg::*;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam logic [VAL_W-1:0] RELEASE_ID = 32'hFFFF_FFFF;
    localparam int IN_PAD_W     = IN_TDATA_W - VAL_W - SEC_W - USEC_W;
    localparam int RANDOM_WORDS = 300;
    localparam int HOLD_CYCLES  = 400;    // long sink stall, fills the four-entry queue
    localparam int TAIL_CYCLES  = 30;     // drain after the last report is seen
    localparam int CYCLE_LIMIT  = 200000;
    localparam int USEC_MAX     = 999999;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata: event_value, time_seconds, time_microseconds, zero pad (lowest bit first)
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // tuser: command
    logic [CMD_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // tdata: contact_id, x_position, y_position, contact_count, scan_time, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // tuser: tip_switch
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    int   fails;
    int   pending;
    int   words_seen;
    int   reports_seen;
    int   words_sent;
    int   cycles;
    logic steady;        // both sides run without gaps while set
    logic hold_go;       // asks the sink for its long stall
    logic hold_done;

    multitouch_slots_to_touch_reports_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    mtsr_report_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt_tvalid (s_axis_tvalid),
        .i_evt_tready (s_axis_tready),
        .i_evt_tdata  (s_axis_tdata),
        .i_evt_tuser  (s_axis_tuser),
        .i_rpt_tvalid (m_axis_tvalid),
        .i_rpt_tready (m_axis_tready),
        .i_rpt_tdata  (m_axis_tdata),
        .i_rpt_tuser  (m_axis_tuser),
        .i_rpt_tlast  (m_axis_tlast),
        .o_fails      (fails),
        .o_pending    (pending),
        .o_words      (words_seen),
        .o_reports    (reports_seen)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog, far above the slowest legal run
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // report sink: random back-pressure, one long stall on request, none while steady
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 36);
            end
        end
    end

    // offers one event word, with random idle cycles ahead of it, and waits for the handshake
    task automatic send_word(input logic [CMD_W-1:0]  code,
                             input logic [VAL_W-1:0]  value,
                             input logic [SEC_W-1:0]  sec,
                             input logic [USEC_W-1:0] usec);
        while (!steady && $urandom_range(99) < 36) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= code;
        s_axis_tdata  <= {{IN_PAD_W{1'b0}}, usec, sec, value};
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // same with a random timestamp
    task automatic send_event(input logic [CMD_W-1:0] code, input logic [VAL_W-1:0] value);
        send_word(code, value, SEC_W'($urandom_range(65535)), USEC_W'($urandom_range(USEC_MAX)));
    endtask

    // one frame: a few slot updates, maybe a stray word, then the sync
    task automatic send_frame();
        int                slots_touched;
        int                pick;
        logic [VAL_W-1:0]  slot_val;
        slots_touched = $urandom_range(4);
        for (int k = 0; k < slots_touched; k++) begin
            pick = $urandom_range(99);
            if (pick < 85)
                slot_val = 32'($urandom_range(SLOTS - 1));
            else if (pick < 95)
                slot_val = 32'($urandom_range(15, SLOTS));
            else
                slot_val = $urandom();
            send_event(CMD_SELECT, slot_val);
            if ($urandom_range(99) < 80)
                send_event(CMD_TRACK, ($urandom_range(99) < 30) ? RELEASE_ID : $urandom());
            if ($urandom_range(99) < 80)
                send_event(CMD_POS_X, $urandom());
            if ($urandom_range(99) < 80)
                send_event(CMD_POS_Y, $urandom());
        end
        // noise: any command code with any value
        if ($urandom_range(99) < 10)
            send_event(CMD_W'($urandom_range(7)), $urandom());
        send_event(CMD_SYNC, $urandom());
    endtask

    initial begin
        int random_start;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_SELECT;
        steady        = 1'b0;
        hold_go       = 1'b0;
        words_sent    = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first sync after reset reports a release for every slot; timestamp at its maximum
        send_word(CMD_SYNC, '0, 16'hFFFF, 20'(USEC_MAX));
        // slot 0: largest positive id, coordinates whose low half is all ones / all zeros
        send_event(CMD_SELECT, 32'd0);
        send_event(CMD_TRACK, 32'h7FFF_FFFF);
        send_event(CMD_POS_X, 32'hFFFF_FFFF);
        send_event(CMD_POS_Y, 32'h8000_0000);
        // last slot: most negative id is still a live contact
        send_event(CMD_SELECT, 32'(SLOTS - 1));
        send_event(CMD_TRACK, 32'h8000_0000);
        send_event(CMD_POS_X, 32'h1234_5678);
        send_event(CMD_POS_Y, 32'h0000_FFFF);
        send_word(CMD_SYNC, '0, '0, '0);
        // out-of-range and negative selects drop the writes behind them
        send_event(CMD_SELECT, 32'(SLOTS));
        send_event(CMD_TRACK, RELEASE_ID);
        send_event(CMD_POS_X, 32'd5);
        send_event(CMD_SELECT, 32'h8000_0000);
        send_event(CMD_POS_Y, 32'd7);
        // ignored codes
        send_event(CMD_RSVD5, RELEASE_ID);
        send_event(CMD_RSVD6, 32'h7FFF_FFFF);
        send_event(CMD_RSVD7, 32'd0);
        send_word(CMD_SYNC, RELEASE_ID, 16'd6553, 20'd99);
        // release slot 0: one release report, then it drops out
        send_event(CMD_SELECT, 32'd0);
        send_event(CMD_TRACK, RELEASE_ID);
        send_event(CMD_SYNC, '0);
        send_event(CMD_SYNC, '0);
        // release the last slot; the sync after that has nothing to report
        send_event(CMD_SELECT, 32'(SLOTS - 1));
        send_event(CMD_TRACK, RELEASE_ID);
        send_event(CMD_SYNC, '0);
        send_event(CMD_SYNC, '0);

        // random frames; one long sink stall early on, then a stretch with no gaps
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            if (words_sent - random_start >= 60)
                hold_go = 1'b1;
            steady = (words_sent - random_start >= 150) && (words_sent - random_start < 230);
            send_frame();
        end
        steady = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // drain: every predicted report must come out, then nothing else may follow
        do @(negedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("tb: %0d event words in, %0d touch reports compared, %0d cycles",
                 words_seen, reports_seen, cycles);
        if (fails == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
